FILE: rtl/core/longest_decreasing_subseq_stream_macros.svh
// Assertion macros for the decreasing-subsequence tracker.
// Included by the top level; needs i_clk and i_rst_n in scope.
`ifndef LONGEST_DECREASING_SUBSEQ_STREAM_MACROS_SVH
`define LONGEST_DECREASING_SUBSEQ_STREAM_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LDSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ldss check failed");

// Next-cycle implication, checked out of reset.
`define LDSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ldss check failed");

`endif

FILE: rtl/core/ldss_pkg.sv
// Shared types, sequencer codes and the search midpoint helper.
// No dependencies.
package ldss_pkg;

    // Widest tail count the block supports (up to 131071 entries, with the full count still fitting).
    localparam int CNT_W_MAX = 17;

    typedef logic [CNT_W_MAX-1:0] t_cnt;

    typedef logic [1:0] t_state;
    localparam t_state S_IDLE   = 2'd0;
    localparam t_state S_SEARCH = 2'd1;
    localparam t_state S_FINISH = 2'd2;

    // Midpoint of [lo, hi), rounded down, without overflow.
    function automatic t_cnt ldss_mid(input t_cnt lo, input t_cnt hi);
        t_cnt span;
        span = hi - lo;
        return lo + (span >> 1);
    endfunction

endpackage

FILE: rtl/core/ldss_tail_mem.sv
// Tail store: one write port, one read port with registered read data.
// No dependencies.
module ldss_tail_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ldss_step.sv
// One binary-search step: compare a fetched tail with the key, narrow the range.
// Uses ldss_pkg for the midpoint helper.
module ldss_step
    import ldss_pkg::*;
#(
    parameter int LEN_W = 11,
    parameter int DW    = 32
) (
    input  logic [LEN_W-1:0] i_lo,
    input  logic [LEN_W-1:0] i_hi,
    input  logic [DW-1:0]    i_tail,
    input  logic [DW-1:0]    i_key,
    output logic [LEN_W-1:0] o_lo,
    output logic [LEN_W-1:0] o_hi,
    output logic [LEN_W-1:0] o_mid,
    output logic             o_more
);

    logic [LEN_W-1:0] w_mid;
    logic             w_greater;

    assign w_mid     = LEN_W'(ldss_mid(t_cnt'(i_lo), t_cnt'(i_hi)));
    // Keys are offset binary, so unsigned order is signed order.
    assign w_greater = i_tail > i_key;

    always_comb begin
        if (w_greater) begin
            o_lo = w_mid + LEN_W'(1);
            o_hi = i_hi;
        end else begin
            o_lo = i_lo;
            o_hi = w_mid;
        end
    end

    assign o_mid  = LEN_W'(ldss_mid(t_cnt'(o_lo), t_cnt'(o_hi)));
    assign o_more = o_lo < o_hi;

endmodule

FILE: rtl/core/longest_decreasing_subseq_stream.sv
// Streaming longest strictly decreasing subsequence tracker (patience method).
// Each accepted request carries one signed value; the block binary-searches a
// strictly decreasing tail store for the first tail <= value, overwrites it or
// appends, and returns one result with the current length. An item passes
// through an accept, then, if the store is not empty, one search step per
// cycle through the shared compare unit (each step reads the tail store's
// single read port), and then a write-back into the store. The input
// is stalled from accept until the result is loaded into the output register;
// a held output only delays the write-back. A request with last set returns the
// sequence answer and then clears the count and the sticky overflow flag. When
// the store is full an append is dropped and overflow stays set until last.
// Depends on ldss_pkg, ldss_step, ldss_tail_mem and the macros header.
`include "longest_decreasing_subseq_stream_macros.svh"

module longest_decreasing_subseq_stream
    import ldss_pkg::*;
#(
    parameter int MAX_LEN     = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [VALUE_WIDTH-1:0]         i_value,
    input  logic                           i_last,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [$clog2(MAX_LEN+1)-1:0]   o_length,
    output logic                           o_overflow,
    output logic                           o_final_res
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int AW    = $clog2(MAX_LEN);
    localparam logic [LEN_W-1:0] FULL = LEN_W'(MAX_LEN);

    // control state
    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             r_out_valid, n_out_valid;

    // per-request working registers
    logic [VALUE_WIDTH-1:0] r_key;
    logic                   r_last;
    logic [LEN_W-1:0]       r_lo, n_lo;
    logic [LEN_W-1:0]       r_hi, n_hi;

    // output payload
    logic [LEN_W-1:0] r_len_o;
    logic             r_ovf_o;
    logic             r_fin_o;

    logic                   w_in_acc;
    logic                   w_fire;
    logic                   w_hit;
    logic [LEN_W-1:0]       w_mid0;
    logic [LEN_W-1:0]       w_new_count;
    logic                   w_new_ovf;
    logic                   w_re;
    logic [AW-1:0]          w_raddr;
    logic                   w_we;
    logic [VALUE_WIDTH-1:0] w_tail;
    logic [LEN_W-1:0]       w_step_lo;
    logic [LEN_W-1:0]       w_step_hi;
    logic [LEN_W-1:0]       w_step_mid;
    logic                   w_step_more;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // write-back goes once the output register is free or draining
    assign w_fire = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    // first probe of a fresh search over [0, count)
    assign w_mid0 = LEN_W'(ldss_mid('0, t_cnt'(r_count)));

    ldss_step #(
        .LEN_W (LEN_W),
        .DW    (VALUE_WIDTH)
    ) u_step (
        .i_lo   (r_lo),
        .i_hi   (r_hi),
        .i_tail (w_tail),
        .i_key  (r_key),
        .o_lo   (w_step_lo),
        .o_hi   (w_step_hi),
        .o_mid  (w_step_mid),
        .o_more (w_step_more)
    );

    // slot found below count: overwrite; otherwise append or drop
    assign w_hit       = r_lo < r_count;
    assign w_we        = w_fire && (w_hit || (r_count != FULL));
    assign w_new_count = (w_hit || (r_count == FULL)) ? r_count : r_count + LEN_W'(1);
    assign w_new_ovf   = r_ovf || (!w_hit && (r_count == FULL));

    ldss_tail_mem #(
        .DEPTH (MAX_LEN),
        .AW    (AW),
        .DW    (VALUE_WIDTH)
    ) u_tails (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_lo[AW-1:0]),
        .i_wdata (r_key),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_tail)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_out_valid = r_out_valid && i_out_stall;
        w_re        = 1'b0;
        w_raddr     = w_mid0[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_lo = '0;
                    n_hi = r_count;
                    if (r_count != '0) begin
                        w_re    = 1'b1;
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SEARCH: begin
                // tail at the previous midpoint is in the read register now
                n_lo = w_step_lo;
                n_hi = w_step_hi;
                if (w_step_more) begin
                    w_re    = 1'b1;
                    w_raddr = w_step_mid[AW-1:0];
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_fire) begin
                    n_out_valid = 1'b1;
                    n_count     = r_last ? '0 : w_new_count;
                    n_ovf       = r_last ? 1'b0 : w_new_ovf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        if (w_in_acc) begin
            // offset binary: flip the sign bit so unsigned compare orders signed values
            r_key  <= {~i_value[VALUE_WIDTH-1], i_value[VALUE_WIDTH-2:0]};
            r_last <= i_last;
        end
        if (w_fire) begin
            r_len_o <= w_new_count;
            r_ovf_o <= w_new_ovf;
            r_fin_o <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_length    = r_len_o;
    assign o_overflow  = r_ovf_o;
    assign o_final_res = r_fin_o;

    // checks
    `LDSS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= FULL)
    `LDSS_ASSERT_NOW(a_search_range, r_state == S_SEARCH, r_lo < r_hi)
    `LDSS_ASSERT_NOW(a_ovf_full, o_out_valid && o_overflow, o_length == FULL)
    `LDSS_ASSERT_NEXT(a_last_clears, w_fire && r_last, (r_count == '0) && !r_ovf)

endmodule
